FILE: src/poa_pkg.sv
// shared types, constants and helpers of the power-on time accumulator
`timescale 1ns / 1ps

package poa_pkg;

    localparam int unsigned CountW = 31;
    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    localparam int unsigned SecM = 60;
    localparam int unsigned SecH = 3600;
    localparam int unsigned SecD = 86400;

    // tier thresholds on the stored total and the save interval of each tier
    localparam logic [CountW-1:0] TierBound0 = CountW'(8 * SecH);
    localparam logic [CountW-1:0] TierBound1 = CountW'(7 * SecD);
    localparam logic [CountW-1:0] TierBound2 = CountW'(30 * SecD);
    localparam logic [CountW-1:0] TierLimit0 = CountW'(15 * SecM);
    localparam logic [CountW-1:0] TierLimit1 = CountW'(1 * SecH);
    localparam logic [CountW-1:0] TierLimit2 = CountW'(6 * SecH);
    localparam logic [CountW-1:0] TierLimit3 = CountW'(1 * SecD);

    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 128;
    localparam int unsigned CfgIdxW  = 2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TOTAL   = 2'd0,
        CFG_MARK    = 2'd1,
        CFG_REBOOTS = 2'd2,
        CFG_SAVES   = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic              save_forced;
        logic              user_active;
        logic [CountW-1:0] uptime_secs;
    } in_item_t;

    typedef struct packed {
        logic [CountW-1:0] save_count;
        logic [CountW-1:0] reboot_count;
        logic [CountW-1:0] saved_uptime_mark;
        logic              save_record;
        logic [CountW-1:0] total_secs;
    } out_item_t;

    function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
                                                  input logic [CountW-1:0] b);
        logic [CountW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CountW] ? CountMax : sum[CountW-1:0];
    endfunction

    function automatic logic [CountW-1:0] tier_limit(input logic [CountW-1:0] total);
        logic [CountW-1:0] lim;
        if (total < TierBound0)
            lim = TierLimit0;
        else if (total < TierBound1)
            lim = TierLimit1;
        else if (total < TierBound2)
            lim = TierLimit2;
        else
            lim = TierLimit3;
        return lim;
    endfunction

endpackage

FILE: src/poweron_time_accumulator.sv
// Power-on time accumulator: counts user-mode seconds and decides when the
// record is saved. One item is accepted per clock cycle while the output is
// not stalled by m_tready; each item passes the input register, then a single
// stage of update logic (one subtract, the tier compares and the saturating
// adds), then the result register. The four configuration registers stand in
// for the stored record and are copied into the live state by the first item
// after reset; later writes do not reach the live state, and reset clears
// the configuration registers too.
`timescale 1ns / 1ps

module poweron_time_accumulator
    import poa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration write port
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CountW-1:0]   cfg_data,
    // item input
    input  logic                s_tvalid,
    output logic                s_tready,
    // tdata: uptime_secs[30:0], user_active[31], save_forced[32], zero fill
    input  logic [InDataW-1:0]  s_tdata,
    // tuser: command
    input  logic                s_tuser,
    // result output
    output logic                m_tvalid,
    input  logic                m_tready,
    // tdata: total_secs[30:0], save_record[31], saved_uptime_mark[62:32],
    //        reboot_count[93:63], save_count[124:94], zero fill
    output logic [OutDataW-1:0] m_tdata
);

    localparam int unsigned InItemW  = $bits(in_item_t);
    localparam int unsigned OutItemW = $bits(out_item_t);

    // configuration registers
    logic [CountW-1:0] cfg_total_reg, cfg_mark_reg, cfg_reboots_reg, cfg_saves_reg;

    // accumulator state
    logic              loaded_reg;
    logic [CountW-1:0] total_store_reg, total_store_next;
    logic [CountW-1:0] uptime_mark_reg, uptime_mark_next;
    logic [CountW-1:0] reboots_store_reg, reboots_store_next;
    logic [CountW-1:0] saves_store_reg, saves_store_next;
    logic              pending_reg, pending_next;
    logic              was_user_mode_reg, was_user_mode_next;

    // input and result registers
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    cmd_t      in_cmd_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg, out_item_next;

    logic advance;

    // working values
    logic [CountW-1:0] eff_total, eff_mark, eff_reboots, eff_saves;
    logic              reboot;
    logic [CountW-1:0] raw_diff, diff;
    logic              pend_upd, trigger, perform;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW - OutItemW){1'b0}}, out_item_reg};

    always_comb
    begin
        // the first item sees the stored record from the configuration registers
        eff_total   = loaded_reg ? total_store_reg   : cfg_total_reg;
        eff_mark    = loaded_reg ? uptime_mark_reg   : cfg_mark_reg;
        eff_reboots = loaded_reg ? reboots_store_reg : cfg_reboots_reg;
        eff_saves   = loaded_reg ? saves_store_reg   : cfg_saves_reg;

        reboot   = in_item_reg.uptime_secs < eff_mark;
        raw_diff = reboot ? in_item_reg.uptime_secs : in_item_reg.uptime_secs - eff_mark;
        diff     = was_user_mode_reg ? raw_diff : '0;

        pend_upd = pending_reg || reboot || (!was_user_mode_reg && in_item_reg.user_active);
        trigger  = in_item_reg.save_forced || pend_upd || (diff >= tier_limit(eff_total));
        perform  = trigger && (in_item_reg.save_forced || (diff != '0));

        total_store_next   = eff_total;
        uptime_mark_next   = eff_mark;
        reboots_store_next = eff_reboots;
        saves_store_next   = eff_saves;
        pending_next       = pending_reg;
        was_user_mode_next = was_user_mode_reg;

        out_item_next.total_secs  = sat_add(eff_total, diff);
        out_item_next.save_record = 1'b0;

        if (in_cmd_reg == CMD_UPDATE)
        begin
            if (reboot)
                reboots_store_next = sat_add(eff_reboots, CountW'(1));
            if (trigger)
                uptime_mark_next = in_item_reg.uptime_secs;
            if (perform)
            begin
                saves_store_next = sat_add(eff_saves, CountW'(1));
                total_store_next = sat_add(eff_total, diff);
            end
            // a trigger with nothing to write leaves the save pending
            pending_next       = perform ? 1'b0 : pend_upd;
            was_user_mode_next = in_item_reg.user_active;

            out_item_next.total_secs  = total_store_next;
            out_item_next.save_record = perform;
        end

        out_item_next.saved_uptime_mark = uptime_mark_next;
        out_item_next.reboot_count      = reboots_store_next;
        out_item_next.save_count        = saves_store_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_total_reg     <= '0;
            cfg_mark_reg      <= '0;
            cfg_reboots_reg   <= '0;
            cfg_saves_reg     <= '0;
            loaded_reg        <= 1'b0;
            total_store_reg   <= '0;
            uptime_mark_reg   <= '0;
            reboots_store_reg <= '0;
            saves_store_reg   <= '0;
            pending_reg       <= 1'b0;
            was_user_mode_reg <= 1'b0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_TOTAL:   cfg_total_reg   <= cfg_data;
                    CFG_MARK:    cfg_mark_reg    <= cfg_data;
                    CFG_REBOOTS: cfg_reboots_reg <= cfg_data;
                    CFG_SAVES:   cfg_saves_reg   <= cfg_data;
                    default:     ;
                endcase
            end

            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                loaded_reg        <= 1'b1;
                total_store_reg   <= total_store_next;
                uptime_mark_reg   <= uptime_mark_next;
                reboots_store_reg <= reboots_store_next;
                saves_store_reg   <= saves_store_next;
                pending_reg       <= pending_next;
                was_user_mode_reg <= was_user_mode_next;
                out_valid_reg     <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item_t'(s_tdata[InItemW-1:0]);
            in_cmd_reg  <= cmd_t'(s_tuser);
        end
        if (advance)
            out_item_reg <= out_item_next;
    end

`ifndef SYNTHESIS
    // a query never writes the record
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_cmd_reg == CMD_QUERY) |=> !out_item_reg.save_record)
        else $error("query produced a record save");

    // once loaded, the accumulated total never goes down
    assert property (@(posedge clk) disable iff (!rst_n)
        (loaded_reg && $past(loaded_reg)) |-> total_store_reg >= $past(total_store_reg))
        else $error("stored total decreased");

    // at most one reboot is counted per transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (loaded_reg && $past(loaded_reg)) |->
            (reboots_store_reg == $past(reboots_store_reg)) ||
            (reboots_store_reg == $past(reboots_store_reg) + CountW'(1)))
        else $error("reboot count moved by more than one");

    // the save count moves only together with a reported save
    assert property (@(posedge clk) disable iff (!rst_n)
        (loaded_reg && $past(loaded_reg) && saves_store_reg != $past(saves_store_reg))
            |-> out_item_reg.save_record)
        else $error("save count changed without a record save");
`endif

endmodule
